// ===== src/dms_pkg.sv =====
// ---------------------------------------------------------------------------
// dms_pkg: shared definitions for the door motor sequencer
// Register map, command and mode codes, configuration and result types.
// ---------------------------------------------------------------------------
package dms_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned IN_DATA_W       = 8;
  localparam int unsigned OUT_DATA_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_STOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_ON   = 3'd5;

  // Reset values
  localparam logic [CFG_W-1:0] MOVE_LIMIT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] BLINK_RST      = 16'd300;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] HOLDOFF_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] END_STOP_RST   = 16'd100;
  localparam logic [CFG_W-1:0] POWER_ON_RST   = 16'd300;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_OPENING = 2'd1,
    MODE_CLOSING = 2'd2
  } door_mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] move_limit_ticks;
    logic [CFG_W-1:0] blink_ticks;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] holdoff_ticks;
    logic [CFG_W-1:0] end_stop_ticks;
    logic [CFG_W-1:0] power_on_ticks;
  } dms_cfg_t;

  // Packed so that motor_power sits in bit 0
  typedef struct packed {
    logic [1:0] door_mode;
    logic       fully_closed;
    logic       locked_lamp;
    logic       status_lamp;
    logic       motor_up;
    logic       motor_power;
  } dms_result_t;

endpackage

// ===== src/dms_core.sv =====
// ---------------------------------------------------------------------------
// dms_core: per-tick state update of the door motor sequencer
// Holds the sequencer state and computes the next state and result of a tick.
// ---------------------------------------------------------------------------
module dms_core #(
  parameter int unsigned TIMER_WIDTH = dms_pkg::TIMER_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                button_raw_i,
  input  logic                end_switch_i,
  input  logic [1:0]          command_i,
  input  dms_pkg::dms_cfg_t   cfg_i,
  output dms_pkg::dms_result_t result_o
);

  localparam int unsigned TW    = TIMER_WIDTH;
  localparam int unsigned CW    = dms_pkg::CFG_W;
  localparam int unsigned CMP_W = (TW > CW) ? TW : CW;

  typedef logic [TW-1:0] tmr_t;
  typedef logic [CW-1:0] cnt_t;

  function automatic tmr_t sat_inc(input tmr_t v);
    return (v == {TW{1'b1}}) ? v : v + TW'(1);
  endfunction

  function automatic logic reached(input tmr_t t, input cnt_t lim);
    return CMP_W'(t) >= CMP_W'(lim);
  endfunction

  dms_pkg::door_mode_e mode_q, mode_d;
  logic moving_q, moving_d, blink_en_q, blink_en_d, lamp_q, lamp_d;
  logic locked_q, locked_d, power_q, power_d, dir_q, dir_d;
  tmr_t move_el_q, move_el_d, blink_el_q, blink_el_d, since_q, since_d;
  tmr_t deb_cnt_q, deb_cnt_d;
  cnt_t stop_cnt_q, stop_cnt_d, pwr_cnt_q, pwr_cnt_d;
  logic stop_armed_q, stop_armed_d, pwr_pend_q, pwr_pend_d;
  logic last_end_q, last_end_d, stable_q, stable_d, prev_btn_q, prev_btn_d;
  logic fell;
  dms_pkg::cmd_e cmd;

  assign cmd = dms_pkg::cmd_e'(command_i);

  always_comb begin
    mode_d       = mode_q;
    moving_d     = moving_q;
    blink_en_d   = blink_en_q;
    lamp_d       = lamp_q;
    locked_d     = locked_q;
    power_d      = power_q;
    dir_d        = dir_q;
    move_el_d    = move_el_q;
    blink_el_d   = blink_el_q;
    deb_cnt_d    = deb_cnt_q;
    stop_cnt_d   = stop_cnt_q;
    pwr_cnt_d    = pwr_cnt_q;
    stop_armed_d = stop_armed_q;
    pwr_pend_d   = pwr_pend_q;
    stable_d     = stable_q;
    fell         = 1'b0;

    since_d = sat_inc(since_q);

    // move timeout
    if (moving_d) begin
      if (reached(move_el_d, cfg_i.move_limit_ticks)) begin
        moving_d = 1'b0; blink_en_d = 1'b0; power_d = 1'b0; pwr_pend_d = 1'b0;
      end else begin
        move_el_d = sat_inc(move_el_d);
      end
    end

    // status lamp
    blink_el_d = sat_inc(blink_el_d);
    if (reached(blink_el_d, cfg_i.blink_ticks)) begin
      blink_el_d = '0;
      lamp_d     = blink_en_d ? !lamp_d : 1'b1;
    end

    // debounce
    if (button_raw_i != prev_btn_q) begin
      deb_cnt_d = '0;
    end else begin
      deb_cnt_d = sat_inc(deb_cnt_d);
    end
    prev_btn_d = button_raw_i;
    if (reached(deb_cnt_d, cfg_i.debounce_ticks) && (button_raw_i != stable_d)) begin
      stable_d = button_raw_i;
      fell     = !button_raw_i;
    end

    // button steps idle -> opening -> closing -> idle
    if (fell && reached(since_d, cfg_i.holdoff_ticks)) begin
      case (mode_d)
        dms_pkg::MODE_IDLE, dms_pkg::MODE_OPENING: begin
          mode_d     = (mode_d == dms_pkg::MODE_IDLE) ? dms_pkg::MODE_OPENING
                                                     : dms_pkg::MODE_CLOSING;
          move_el_d  = '0;
          moving_d   = 1'b1;
          blink_en_d = 1'b1;
          dir_d      = (mode_d == dms_pkg::MODE_OPENING);
          pwr_pend_d = 1'b1;
          pwr_cnt_d  = cfg_i.power_on_ticks;
        end
        default: begin
          mode_d   = dms_pkg::MODE_IDLE;
          moving_d = 1'b0; blink_en_d = 1'b0; power_d = 1'b0; pwr_pend_d = 1'b0;
        end
      endcase
      since_d = '0;
    end

    // end switch rise while closing
    if ((mode_d == dms_pkg::MODE_CLOSING) && end_switch_i && !last_end_q) begin
      locked_d     = 1'b1;
      stop_armed_d = 1'b1;
      stop_cnt_d   = cfg_i.end_stop_ticks;
    end
    if (stop_armed_d) begin
      if (stop_cnt_d == '0) begin
        moving_d = 1'b0; blink_en_d = 1'b0; power_d = 1'b0; pwr_pend_d = 1'b0;
        stop_armed_d = 1'b0;
      end else begin
        stop_cnt_d = stop_cnt_d - CW'(1);
      end
    end
    last_end_d = end_switch_i;

    // commands
    case (cmd)
      dms_pkg::CMD_OPEN, dms_pkg::CMD_CLOSE: begin
        if ((cmd == dms_pkg::CMD_OPEN) ? (mode_d != dms_pkg::MODE_OPENING)
                                       : (mode_d != dms_pkg::MODE_CLOSING)) begin
          mode_d     = (cmd == dms_pkg::CMD_OPEN) ? dms_pkg::MODE_OPENING
                                                  : dms_pkg::MODE_CLOSING;
          move_el_d  = '0;
          moving_d   = 1'b1;
          blink_en_d = 1'b1;
          dir_d      = (cmd == dms_pkg::CMD_OPEN);
          pwr_pend_d = 1'b1;
          pwr_cnt_d  = cfg_i.power_on_ticks;
        end
        since_d = '0;
      end
      dms_pkg::CMD_STOP: begin
        if (moving_d) begin
          mode_d   = dms_pkg::MODE_IDLE;
          moving_d = 1'b0; blink_en_d = 1'b0; power_d = 1'b0; pwr_pend_d = 1'b0;
        end
        since_d = '0;
      end
      default: ;
    endcase

    // delayed power enable
    if (pwr_pend_d) begin
      if (pwr_cnt_d == '0) begin
        power_d    = 1'b1;
        pwr_pend_d = 1'b0;
      end else begin
        pwr_cnt_d = pwr_cnt_d - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dms_pkg::MODE_IDLE;
      moving_q     <= 1'b0;
      blink_en_q   <= 1'b0;
      lamp_q       <= 1'b0;
      locked_q     <= 1'b0;
      power_q      <= 1'b0;
      dir_q        <= 1'b0;
      move_el_q    <= '0;
      blink_el_q   <= '0;
      since_q      <= '0;
      deb_cnt_q    <= '0;
      stop_cnt_q   <= '0;
      pwr_cnt_q    <= '0;
      stop_armed_q <= 1'b0;
      pwr_pend_q   <= 1'b0;
      last_end_q   <= 1'b1;
      stable_q     <= 1'b0;
      prev_btn_q   <= 1'b0;
    end else if (tick_i) begin
      mode_q       <= mode_d;
      moving_q     <= moving_d;
      blink_en_q   <= blink_en_d;
      lamp_q       <= lamp_d;
      locked_q     <= locked_d;
      power_q      <= power_d;
      dir_q        <= dir_d;
      move_el_q    <= move_el_d;
      blink_el_q   <= blink_el_d;
      since_q      <= since_d;
      deb_cnt_q    <= deb_cnt_d;
      stop_cnt_q   <= stop_cnt_d;
      pwr_cnt_q    <= pwr_cnt_d;
      stop_armed_q <= stop_armed_d;
      pwr_pend_q   <= pwr_pend_d;
      last_end_q   <= last_end_d;
      stable_q     <= stable_d;
      prev_btn_q   <= prev_btn_d;
    end
  end

  assign result_o.motor_power  = power_d;
  assign result_o.motor_up     = dir_d;
  assign result_o.status_lamp  = lamp_d;
  assign result_o.locked_lamp  = locked_d;
  assign result_o.fully_closed = !end_switch_i;
  assign result_o.door_mode    = mode_d;

endmodule

// ===== src/door_motor_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// door_motor_sequencer_top: garage door motor sequencer
// Stream wrapper with configuration registers and result output register.
// ---------------------------------------------------------------------------
// Each request on the slave stream is one millisecond tick carrying the raw
// button level, the end switch level and an optional open/close/stop command.
// Each tick yields exactly one result on the master stream: relay drives,
// lamps, the fully-closed flag and the door mode.
// The tick's state update is done in the cycle it is taken and the result
// lands in the output register. A new tick can be taken every cycle; the
// only limit is the single output register, so s_axis_tready drops only
// while a result is held and the receiver stalls.
// Timing registers are written through the cfg channel (always ready), one
// 16-bit register per write; the user must do so only while no tick is in
// flight, as the block does not enforce it. Reset returns the sequencer
// state and timing registers to defaults; no result is pending after reset.
// ---------------------------------------------------------------------------
module door_motor_sequencer_top #(
  parameter int unsigned TIMER_WIDTH = dms_pkg::TIMER_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] button_raw, [1] end_switch, [3:2] command, [7:4] zero
  input  logic [dms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] motor_power, [1] motor_up, [2] status_lamp, [3] locked_lamp,
  // [4] fully_closed, [6:5] door_mode, [7] zero
  output logic [dms_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dms_pkg::CFG_W-1:0]          cfg_data_i
);

  dms_pkg::dms_cfg_t    cfg_q;
  dms_pkg::dms_result_t result, result_q;
  logic                 out_valid_q;
  logic                 tick;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_limit_ticks <= dms_pkg::MOVE_LIMIT_RST;
      cfg_q.blink_ticks      <= dms_pkg::BLINK_RST;
      cfg_q.debounce_ticks   <= dms_pkg::DEBOUNCE_RST;
      cfg_q.holdoff_ticks    <= dms_pkg::HOLDOFF_RST;
      cfg_q.end_stop_ticks   <= dms_pkg::END_STOP_RST;
      cfg_q.power_on_ticks   <= dms_pkg::POWER_ON_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dms_pkg::REG_MOVE_LIMIT: cfg_q.move_limit_ticks <= cfg_data_i;
        dms_pkg::REG_BLINK:      cfg_q.blink_ticks      <= cfg_data_i;
        dms_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data_i;
        dms_pkg::REG_HOLDOFF:    cfg_q.holdoff_ticks    <= cfg_data_i;
        dms_pkg::REG_END_STOP:   cfg_q.end_stop_ticks   <= cfg_data_i;
        dms_pkg::REG_POWER_ON:   cfg_q.power_on_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dms_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .button_raw_i (s_axis_tdata[0]),
    .end_switch_i (s_axis_tdata[1]),
    .command_i    (s_axis_tdata[3:2]),
    .cfg_i        (cfg_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

endmodule

// ===== src/dms_checker.sv =====
// ---------------------------------------------------------------------------
// dms_checker: port-level checks for the door motor sequencer
// Bound to the top level; watches the tick and result streams.
// ---------------------------------------------------------------------------
module dms_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [dms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dms_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic in_req;
  assign in_req = s_axis_tvalid && s_axis_tready;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every accepted tick shows a result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> m_axis_tvalid)
    else $error("tick without result");

  // a stalled result must block new ticks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("tick taken over a held result");

  // fully-closed follows the tick's end switch
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> m_axis_tdata[4] == !$past(s_axis_tdata[1]))
    else $error("fully_closed mismatch");

  // a stop request always leaves the motor unpowered
  a_stop_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req && (s_axis_tdata[3:2] == dms_pkg::CMD_STOP) |=> !m_axis_tdata[0])
    else $error("power on after stop");

endmodule

bind door_motor_sequencer_top dms_checker u_dms_checker (.*);

// ===== tb/sv/door_motor_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// door_motor_sequencer_top_tb: self-checking bench for the door sequencer
// Drives tick requests with random bursts and gaps and stalls the result
// stream on its own pattern. Every tick's result is predicted by a
// cycle-free model of the sequencer or given by a scripted row, and compared
// field by field. After a scripted run at reset values, timing registers are
// rewritten per phase: low, fixed small, highest and random small values.
// ---------------------------------------------------------------------------
module door_motor_sequencer_top_tb;

  localparam int unsigned TW         = dms_pkg::TIMER_WIDTH_DEF;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_LEN  = 100;
  localparam int unsigned LONG_HOLD  = 150;
  localparam int unsigned SETTLE     = 4;
  localparam int unsigned CYCLE_CAP  = 200000;

  localparam logic [dms_pkg::CFG_IDX_W-1:0] REG_ORDER [6] = '{
    dms_pkg::REG_MOVE_LIMIT, dms_pkg::REG_BLINK, dms_pkg::REG_DEBOUNCE,
    dms_pkg::REG_HOLDOFF, dms_pkg::REG_END_STOP, dms_pkg::REG_POWER_ON
  };

  typedef struct {
    logic                 btn;
    logic                 end_sw;
    dms_pkg::cmd_e        cmd;
    bit                   typed;
    dms_pkg::dms_result_t want;
  } tick_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [dms_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [dms_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [dms_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [dms_pkg::CFG_W-1:0]       cfg_data_i = '0;

  door_motor_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Sequencer state mirror, reset values as after rst_ni
  dms_pkg::dms_cfg_t   cfg_shadow = '{dms_pkg::MOVE_LIMIT_RST, dms_pkg::BLINK_RST,
                                      dms_pkg::DEBOUNCE_RST, dms_pkg::HOLDOFF_RST,
                                      dms_pkg::END_STOP_RST, dms_pkg::POWER_ON_RST};
  dms_pkg::door_mode_e st_mode = dms_pkg::MODE_IDLE;
  logic         st_moving = 1'b0, st_blink_on = 1'b0, st_lamp = 1'b0;
  logic         st_locked = 1'b0, st_power = 1'b0, st_dir = 1'b0;
  logic         st_stop_armed = 1'b0, st_pwr_pending = 1'b0;
  logic         st_last_end = 1'b1, st_stable_btn = 1'b0, st_prev_btn = 1'b0;
  logic [TW-1:0] st_move_cnt = '0, st_blink_cnt = '0, st_since = '0;
  logic [TW-1:0] st_stop_cnt = '0, st_pwr_cnt = '0, st_db_cnt = '0;

  dms_pkg::dms_result_t      door_outputs_due [$];
  logic [dms_pkg::CFG_W-1:0] reg_plan [6];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;
  bit           long_hold_req = 1'b0;

  function automatic logic [TW-1:0] sat_up(input logic [TW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void cut_motor();
    st_moving      = 1'b0;
    st_blink_on    = 1'b0;
    st_power       = 1'b0;
    st_pwr_pending = 1'b0;
  endfunction

  function automatic void begin_move(input dms_pkg::door_mode_e m);
    st_mode        = m;
    st_move_cnt    = '0;
    st_moving      = 1'b1;
    st_blink_on    = 1'b1;
    st_dir         = (m == dms_pkg::MODE_OPENING);
    st_pwr_pending = 1'b1;
    st_pwr_cnt     = cfg_shadow.power_on_ticks;
  endfunction

  // One millisecond tick of the sequencer
  function automatic dms_pkg::dms_result_t step_door(input logic btn, input logic end_sw,
                                                     input dms_pkg::cmd_e cmd);
    logic                 fell;
    dms_pkg::dms_result_t r;
    fell = 1'b0;
    st_since = sat_up(st_since);

    if (st_moving) begin
      if (st_move_cnt >= cfg_shadow.move_limit_ticks) cut_motor();
      else st_move_cnt = sat_up(st_move_cnt);
    end

    st_blink_cnt = sat_up(st_blink_cnt);
    if (st_blink_cnt >= cfg_shadow.blink_ticks) begin
      st_blink_cnt = '0;
      st_lamp = st_blink_on ? !st_lamp : 1'b1;
    end

    if (btn != st_prev_btn) st_db_cnt = '0;
    else st_db_cnt = sat_up(st_db_cnt);
    st_prev_btn = btn;
    if (st_db_cnt >= cfg_shadow.debounce_ticks && btn != st_stable_btn) begin
      st_stable_btn = btn;
      fell = !btn;
    end

    if (fell && st_since >= cfg_shadow.holdoff_ticks) begin
      case (st_mode)
        dms_pkg::MODE_IDLE:    begin_move(dms_pkg::MODE_OPENING);
        dms_pkg::MODE_OPENING: begin_move(dms_pkg::MODE_CLOSING);
        default: begin
          st_mode = dms_pkg::MODE_IDLE;
          cut_motor();
        end
      endcase
      st_since = '0;
    end

    if (st_mode == dms_pkg::MODE_CLOSING && end_sw && !st_last_end) begin
      st_locked     = 1'b1;
      st_stop_armed = 1'b1;
      st_stop_cnt   = cfg_shadow.end_stop_ticks;
    end
    if (st_stop_armed) begin
      if (st_stop_cnt == '0) begin
        cut_motor();
        st_stop_armed = 1'b0;
      end else begin
        st_stop_cnt = st_stop_cnt - 1'b1;
      end
    end
    st_last_end = end_sw;

    case (cmd)
      dms_pkg::CMD_OPEN: begin
        if (st_mode != dms_pkg::MODE_OPENING) begin_move(dms_pkg::MODE_OPENING);
        st_since = '0;
      end
      dms_pkg::CMD_CLOSE: begin
        if (st_mode != dms_pkg::MODE_CLOSING) begin_move(dms_pkg::MODE_CLOSING);
        st_since = '0;
      end
      dms_pkg::CMD_STOP: begin
        if (st_moving) begin
          st_mode = dms_pkg::MODE_IDLE;
          cut_motor();
        end
        st_since = '0;
      end
      default: ;
    endcase

    if (st_pwr_pending) begin
      if (st_pwr_cnt == '0) begin
        st_power       = 1'b1;
        st_pwr_pending = 1'b0;
      end else begin
        st_pwr_cnt = st_pwr_cnt - 1'b1;
      end
    end

    r.motor_power  = st_power;
    r.motor_up     = st_dir;
    r.status_lamp  = st_lamp;
    r.locked_lamp  = st_locked;
    r.fully_closed = !end_sw;
    r.door_mode    = st_mode;
    return r;
  endfunction

  function automatic tick_row_t mk(input int unsigned btn, input int unsigned end_sw,
                                   input dms_pkg::cmd_e cmd, input int unsigned typed,
                                   input int unsigned pw, input int unsigned up,
                                   input int unsigned lamp, input int unsigned lock,
                                   input int unsigned fc, input dms_pkg::door_mode_e m);
    tick_row_t t;
    t.btn    = 1'(btn);
    t.end_sw = 1'(end_sw);
    t.cmd    = cmd;
    t.typed  = (typed != 0);
    t.want   = '{door_mode: m, fully_closed: 1'(fc), locked_lamp: 1'(lock),
                 status_lamp: 1'(lamp), motor_up: 1'(up), motor_power: 1'(pw)};
    return t;
  endfunction

  // Offer one tick request, predict its result once taken, then maybe idle
  task automatic send_tick(input logic btn, input logic end_sw, input dms_pkg::cmd_e cmd,
                           input bit typed, input dms_pkg::dms_result_t want);
    dms_pkg::dms_result_t pred;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, cmd, end_sw, btn};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = step_door(btn, end_sw, cmd);
    door_outputs_due.push_back(typed ? want : pred);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (door_outputs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs();
    int i;
    for (i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= REG_ORDER[i];
      cfg_data_i  <= reg_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (REG_ORDER[i])
        dms_pkg::REG_MOVE_LIMIT: cfg_shadow.move_limit_ticks = reg_plan[i];
        dms_pkg::REG_BLINK:      cfg_shadow.blink_ticks      = reg_plan[i];
        dms_pkg::REG_DEBOUNCE:   cfg_shadow.debounce_ticks   = reg_plan[i];
        dms_pkg::REG_HOLDOFF:    cfg_shadow.holdoff_ticks    = reg_plan[i];
        dms_pkg::REG_END_STOP:   cfg_shadow.end_stop_ticks   = reg_plan[i];
        default:                 cfg_shadow.power_on_ticks   = reg_plan[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned due,
                                      input int unsigned got);
    if (due != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, due, got);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin : result_check
    dms_pkg::dms_result_t got, due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[6:0];
      if (door_outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        due = door_outputs_due.pop_front();
        check_field("motor_power", 32'(due.motor_power), 32'(got.motor_power));
        check_field("motor_up", 32'(due.motor_up), 32'(got.motor_up));
        check_field("status_lamp", 32'(due.status_lamp), 32'(got.status_lamp));
        check_field("locked_lamp", 32'(due.locked_lamp), 32'(got.locked_lamp));
        check_field("fully_closed", 32'(due.fully_closed), 32'(got.fully_closed));
        check_field("door_mode", 32'(due.door_mode), 32'(got.door_mode));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("door_motor_sequencer_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver pacing; one long hold-off so the output register fills up
  initial begin : rx_pacing
    int unsigned style, span, tick;
    bit          held;
    held = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(10, 80);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk_i);
        if (long_hold_req && !held) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
        end
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
          2:       m_axis_tready <= (tick % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    tick_row_t            script [$];
    dms_pkg::dms_result_t none_due;
    int unsigned          p, n, btn_left, end_left, db_span;
    logic                 btn_lvl, end_lvl;
    dms_pkg::cmd_e        cmd;

    none_due = '0;
    // Reset timings: opening, closing, lock on end switch rise, stop
    script.push_back(mk(0, 1, dms_pkg::CMD_NONE,  1, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 0, dms_pkg::CMD_NONE,  1, 0, 0, 0, 0, 1, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 0, dms_pkg::CMD_OPEN,  1, 0, 1, 0, 0, 1, dms_pkg::MODE_OPENING));
    script.push_back(mk(0, 0, dms_pkg::CMD_OPEN,  1, 0, 1, 0, 0, 1, dms_pkg::MODE_OPENING));
    script.push_back(mk(0, 1, dms_pkg::CMD_NONE,  1, 0, 1, 0, 0, 0, dms_pkg::MODE_OPENING));
    script.push_back(mk(0, 0, dms_pkg::CMD_CLOSE, 1, 0, 0, 0, 0, 1, dms_pkg::MODE_CLOSING));
    script.push_back(mk(0, 1, dms_pkg::CMD_NONE,  1, 0, 0, 0, 1, 0, dms_pkg::MODE_CLOSING));
    script.push_back(mk(0, 1, dms_pkg::CMD_STOP,  1, 0, 0, 0, 1, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 1, dms_pkg::CMD_STOP,  1, 0, 0, 0, 1, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(1, 1, dms_pkg::CMD_NONE,  0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(1, 0, dms_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 1, dms_pkg::CMD_NONE,  0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(1, 0, dms_pkg::CMD_OPEN,  0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 1, dms_pkg::CMD_STOP,  0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(1, 1, dms_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));
    script.push_back(mk(0, 0, dms_pkg::CMD_NONE,  0, 0, 0, 0, 0, 0, dms_pkg::MODE_IDLE));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i])
      send_tick(script[i].btn, script[i].end_sw, script[i].cmd, script[i].typed,
                script[i].want);
    settle();

    btn_lvl  = 1'b0;
    end_lvl  = 1'b1;
    btn_left = 0;
    end_left = 0;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: reg_plan = '{16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0};
        1: reg_plan = '{16'd8, 16'd3, 16'd2, 16'd4, 16'd3, 16'd2};
        2: reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        default: begin
          reg_plan[0] = dms_pkg::CFG_W'($urandom_range(1, 60));
          reg_plan[1] = dms_pkg::CFG_W'($urandom_range(1, 12));
          reg_plan[2] = dms_pkg::CFG_W'($urandom_range(1, 6));
          reg_plan[3] = dms_pkg::CFG_W'($urandom_range(0, 15));
          reg_plan[4] = dms_pkg::CFG_W'($urandom_range(0, 12));
          reg_plan[5] = dms_pkg::CFG_W'($urandom_range(0, 12));
        end
      endcase
      write_regs();
      db_span = (cfg_shadow.debounce_ticks > 20) ? 32'd20
                                                 : 32'(cfg_shadow.debounce_ticks);

      for (n = 0; n < PHASE_LEN; n++) begin
        // button held long enough to pass debounce (if at most 20 ticks), with some bounce mixed in
        if (btn_left == 0) begin
          btn_lvl = !btn_lvl;
          if ($urandom_range(0, 4) == 0) btn_left = $urandom_range(1, 2);
          else btn_left = db_span + $urandom_range(1, 6);
        end
        btn_left--;
        if (end_left == 0) begin
          end_lvl  = !end_lvl;
          end_left = $urandom_range(1, 15);
        end
        end_left--;
        if ($urandom_range(0, 7) == 0) cmd = dms_pkg::cmd_e'($urandom_range(0, 3));
        else cmd = dms_pkg::CMD_NONE;
        if (p == 1 && n == 30) long_hold_req = 1'b1;
        send_tick(btn_lvl, end_lvl, cmd, 1'b0, none_due);
      end
      settle();
    end

    if (mismatches == 0 && door_outputs_due.size() == 0) begin
      $display("door_motor_sequencer_top_tb: PASS");
    end else begin
      $display("door_motor_sequencer_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== door_motor_sequencer_top.f =====
src/dms_pkg.sv
src/dms_core.sv
src/door_motor_sequencer_top.sv
src/dms_checker.sv
tb/sv/door_motor_sequencer_top_tb.sv
